[rtl/eafsc_pkg.sv]
// Shared constants for the electrical angle block: sample and angle widths,
// the CORDIC step count and the arctangent table in binary angle units.
// Depends on nothing; every other file imports it.
package eafsc_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD_SHIFT  = 24;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_BITS  = SAMPLE_BITS + GUARD_SHIFT + 3;
    localparam int ANGLE_BITS   = 32;
    localparam int PP_BITS      = 5;
    localparam int DEG_BITS     = 17;
    localparam int PROD_BITS    = ANGLE_BITS + DEG_BITS;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [DEG_BITS-1:0]   DEG_Q8_FULL  = 17'd92160;
    localparam logic [PP_BITS-1:0]    PP_RESET     = 5'd1;

    localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

endpackage

[rtl/eafsc_if.sv]
// Valid/ready channel interfaces for sample pairs, angle results and the
// pole-pair register write. Depends on eafsc_pkg for the field widths.
interface eafsc_sample_if
    import eafsc_pkg::*;
    ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sine_sample;
    logic signed [SAMPLE_BITS-1:0] cosine_sample;

    modport source (output valid, output sine_sample, output cosine_sample, input ready);
    modport sink   (input valid, input sine_sample, input cosine_sample, output ready);
endinterface

interface eafsc_angle_if
    import eafsc_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [DEG_BITS-1:0] electrical_angle;

    modport source (output valid, output electrical_angle, input ready);
    modport sink   (input valid, input electrical_angle, output ready);
endinterface

interface eafsc_cfg_if
    import eafsc_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [PP_BITS-1:0] pole_pairs;

    modport source (output valid, output pole_pairs, input ready);
    modport sink   (input valid, input pole_pairs, output ready);
endinterface

[rtl/electrical_angle_from_sin_cos_top.sv]
// Top level: CORDIC pipeline, pole-pair scaling, degree conversion and the
// output register with skid stage. Depends on eafsc_pkg, eafsc_if, eafsc_cordic.

// The block turns each sine/cosine sample pair into an electrical angle in
// degrees (Q9.8, always below 360) and accepts a new pair in every cycle
// while input ready is high. A result passes through the input stage, which
// captures the pair at its transfer edge, one register stage per CORDIC
// iteration, two multiplier stages and the output register. Input ready drops
// only when both the output register and the skid stage hold results that
// have not been taken.
// Pole pairs reset to one and should be written only while the block is idle.
module electrical_angle_from_sin_cos_top
    import eafsc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    eafsc_sample_if.sink   samples,
    eafsc_angle_if.source  result,
    eafsc_cfg_if.sink      cfg
);

    logic [PP_BITS-1:0]    pole_pairs_reg;
    logic                  en;
    logic                  mech_valid;
    logic [ANGLE_BITS-1:0] mech_angle;

    logic                  elec_valid_reg;
    logic [ANGLE_BITS-1:0] elec_reg;
    logic [ANGLE_BITS-1:0] elec_next;
    logic                  prod_valid_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [PROD_BITS-1:0]  rounded;
    logic [DEG_BITS-1:0]   deg_next;

    logic                  out_valid_reg;
    logic [DEG_BITS-1:0]   out_reg;
    logic                  skid_valid_reg;
    logic [DEG_BITS-1:0]   skid_reg;
    logic                  push;
    logic                  take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_pairs_reg <= PP_RESET;
        end
        else if (cfg.valid)
        begin
            pole_pairs_reg <= cfg.pole_pairs;
        end
    end

    assign en            = !skid_valid_reg;
    assign samples.ready = en;

    eafsc_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (samples.valid),
        .sine      (samples.sine_sample),
        .cosine    (samples.cosine_sample),
        .out_valid (mech_valid),
        .out_angle (mech_angle)
    );

    assign elec_next = mech_angle * ANGLE_BITS'(pole_pairs_reg);
    assign rounded   = prod_reg + PROD_BITS'(HALF_TURN);

    always_comb
    begin
        deg_next = rounded[PROD_BITS-1:ANGLE_BITS];
        if (deg_next >= DEG_Q8_FULL)
        begin
            deg_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elec_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            elec_valid_reg <= mech_valid;
            prod_valid_reg <= elec_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            elec_reg <= elec_next;
            prod_reg <= PROD_BITS'(elec_reg) * PROD_BITS'(DEG_Q8_FULL);
        end
    end

    assign push = en && prod_valid_reg;
    assign take = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (take || !out_valid_reg)
        begin
            out_reg <= deg_next;
        end
        else if (push)
        begin
            skid_reg <= deg_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.electrical_angle = out_reg;

endmodule

[rtl/eafsc_cordic.sv]
// Pipelined vectoring CORDIC: an input stage with quadrant pre-rotation and
// axis cases, then one register stage per iteration. Depends on eafsc_pkg.
module eafsc_cordic
    import eafsc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] sine,
    input  logic signed [SAMPLE_BITS-1:0] cosine,
    output logic                          out_valid,
    output logic [ANGLE_BITS-1:0]         out_angle
);

    typedef struct packed {
        logic                          axis;
        logic signed [CORDIC_BITS-1:0] x;
        logic signed [CORDIC_BITS-1:0] y;
        logic [ANGLE_BITS-1:0]         z;
    } stage_t;

    stage_t stage_reg  [CORDIC_STEPS+1];
    stage_t stage_next [CORDIC_STEPS+1];
    logic   valid_reg  [CORDIC_STEPS+1];

    logic signed [CORDIC_BITS-1:0] s_wide;
    logic signed [CORDIC_BITS-1:0] c_wide;

    always_comb
    begin
        s_wide = {{(CORDIC_BITS-SAMPLE_BITS){sine[SAMPLE_BITS-1]}}, sine} <<< GUARD_SHIFT;
        c_wide = {{(CORDIC_BITS-SAMPLE_BITS){cosine[SAMPLE_BITS-1]}}, cosine} <<< GUARD_SHIFT;
        stage_next[0].axis = 1'b0;
        stage_next[0].x    = c_wide;
        stage_next[0].y    = s_wide;
        stage_next[0].z    = '0;
        if (cosine == '0)
        begin
            stage_next[0].axis = 1'b1;
            if (sine > 0)
            begin
                stage_next[0].z = QUARTER_TURN;
            end
            else if (sine < 0)
            begin
                stage_next[0].z = -QUARTER_TURN;
            end
        end
        else if (sine == '0)
        begin
            stage_next[0].axis = 1'b1;
            stage_next[0].z    = (cosine > 0) ? '0 : HALF_TURN;
        end
        else if (cosine < 0)
        begin
            if (sine >= 0)
            begin
                stage_next[0].x = s_wide;
                stage_next[0].y = -c_wide;
                stage_next[0].z = QUARTER_TURN;
            end
            else
            begin
                stage_next[0].x = -s_wide;
                stage_next[0].y = c_wide;
                stage_next[0].z = -QUARTER_TURN;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CORDIC_BITS-1:0] dx;
        logic signed [CORDIC_BITS-1:0] dy;

        always_comb
        begin
            dx = stage_reg[i].y >>> i;
            dy = stage_reg[i].x >>> i;
            stage_next[i+1] = stage_reg[i];
            if (!stage_reg[i].axis)
            begin
                if (stage_reg[i].y > 0)
                begin
                    stage_next[i+1].x = stage_reg[i].x + dx;
                    stage_next[i+1].y = stage_reg[i].y - dy;
                    stage_next[i+1].z = stage_reg[i].z + ATAN_TURNS[i];
                end
                else
                begin
                    stage_next[i+1].x = stage_reg[i].x - dx;
                    stage_next[i+1].y = stage_reg[i].y + dy;
                    stage_next[i+1].z = stage_reg[i].z - ATAN_TURNS[i];
                end
            end
        end
    end

    for (genvar k = 0; k <= CORDIC_STEPS; k++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_angle = stage_reg[CORDIC_STEPS].z;

endmodule

[rtl/eafsc_checker.sv]
// Port-level checker for the electrical angle block, bound to the top level.
// Depends on eafsc_pkg and the top level's interface ports.
module eafsc_checker
    import eafsc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [DEG_BITS-1:0] out_angle
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_angle))
        else $error("Stalled result transfer changed or was dropped.");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_angle < DEG_Q8_FULL)
        else $error("Electrical angle reached a full turn.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("Input stalled without a stalled result transfer.");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("Input stalled while no result was offered.");

endmodule

bind electrical_angle_from_sin_cos_top eafsc_checker u_eafsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (samples.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_angle (result.electrical_angle)
);

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for electrical_angle_from_sin_cos_top. Checks every angle against a CORDIC model
// in a scoreboard class, under random gaps, stalls and pole-pair settings.
// Depends on eafsc_pkg, the eafsc_if interfaces and the RTL of the block.
module tb;
    import eafsc_pkg::*;

    class angle_scoreboard;
        logic [PP_BITS-1:0]  pole_pairs;
        logic [DEG_BITS-1:0] expected_angles[$];
        int                  errors;

        function new();
            pole_pairs = PP_RESET;
            errors     = 0;
        endfunction

        function logic [ANGLE_BITS-1:0] turn_atan2(longint y, longint x);
            logic [ANGLE_BITS-1:0] z;
            longint                t;
            longint                dx;
            longint                dy;
            z = '0;
            if (x == 0)
            begin
                if (y > 0)
                    return QUARTER_TURN;
                if (y < 0)
                    return -QUARTER_TURN;
                return '0;
            end
            if (y == 0)
                return (x > 0) ? '0 : HALF_TURN;
            x = x <<< GUARD_SHIFT;
            y = y <<< GUARD_SHIFT;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = QUARTER_TURN;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -QUARTER_TURN;
                end
            end
            for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TURNS[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TURNS[i];
                end
            end
            return z;
        endfunction

        function logic [DEG_BITS-1:0] predict_angle(logic signed [SAMPLE_BITS-1:0] s,
                                                    logic signed [SAMPLE_BITS-1:0] c);
            logic [ANGLE_BITS-1:0] mech;
            logic [ANGLE_BITS-1:0] elec;
            longint unsigned       prod;
            longint unsigned       deg;
            mech = turn_atan2(longint'(s), longint'(c));
            prod = 64'(mech) * 64'(pole_pairs);
            elec = prod[ANGLE_BITS-1:0];
            deg  = (64'(elec) * 64'(DEG_Q8_FULL) + 64'h8000_0000) >> 32;
            if (deg >= 64'(DEG_Q8_FULL))
                deg = 0;
            return deg[DEG_BITS-1:0];
        endfunction

        function void note_pair(logic signed [SAMPLE_BITS-1:0] s,
                                logic signed [SAMPLE_BITS-1:0] c);
            expected_angles.push_back(predict_angle(s, c));
        endfunction

        function void check_angle(logic [DEG_BITS-1:0] got);
            logic [DEG_BITS-1:0] want;
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected angle transfer, actual %0d", $time, got);
                errors++;
                return;
            end
            want = expected_angles.pop_front();
            if (got !== want)
            begin
                $display("%0t: angle mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 219;
    localparam int DIRECTED       = 20;

    logic clk;
    logic rst_n;
    logic gaps_on;
    int   quiet_cycles;
    int   stall_left;

    angle_scoreboard sb = new();

    eafsc_sample_if sample_ch ();
    eafsc_angle_if  angle_ch ();
    eafsc_cfg_if    cfg_ch ();

    electrical_angle_from_sin_cos_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .result  (angle_ch),
        .cfg     (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] s,
                             input logic signed [SAMPLE_BITS-1:0] c);
        int gap;
        sample_ch.valid         <= 1'b1;
        sample_ch.sine_sample   <= s;
        sample_ch.cosine_sample <= c;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_pair(s, c);
        gap = (gaps_on && $urandom_range(0, 99) >= 70) ? gap_len() : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_pole_pairs(input logic [PP_BITS-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.pole_pairs <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.pole_pairs = value;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_pair(output logic signed [SAMPLE_BITS-1:0] s,
                               output logic signed [SAMPLE_BITS-1:0] c);
        int kind;
        int m;
        kind = $urandom_range(0, 99);
        s    = SAMPLE_BITS'($urandom);
        c    = SAMPLE_BITS'($urandom);
        if (kind >= 40 && kind < 60)
        begin
            s = SAMPLE_BITS'(int'($urandom_range(0, 510)) - 255);
            c = SAMPLE_BITS'(int'($urandom_range(0, 510)) - 255);
        end
        else if (kind >= 60 && kind < 75)
        begin
            if ($urandom_range(0, 1))
                s = '0;
            else
                c = '0;
        end
        else if (kind >= 75 && kind < 85)
        begin
            m = $urandom_range(1, 3);
            if ($urandom_range(0, 1))
                m = -m;
            if ($urandom_range(0, 1))
                s = SAMPLE_BITS'(m);
            else
                c = SAMPLE_BITS'(m);
        end
        else if (kind >= 85)
        begin
            c = $urandom_range(0, 1) ? s : -s;
        end
    endtask

    initial
    begin
        angle_ch.ready <= 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                angle_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 99) < 15)
            begin
                stall_left = gap_len() - 1;
                angle_ch.ready <= 1'b0;
            end
            else
            begin
                angle_ch.ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && angle_ch.valid && angle_ch.ready)
            sb.check_angle(angle_ch.electrical_angle);
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (angle_ch.valid && angle_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int                            dir_s [DIRECTED];
        int                            dir_c [DIRECTED];
        int                            phase_pp [PHASES];
        logic signed [SAMPLE_BITS-1:0] s;
        logic signed [SAMPLE_BITS-1:0] c;

        dir_s = '{0, 8388607, -8388608, 0, 0, 8388607, -8388608, 8388607, -8388608, -1,
                  1, -1, 1, -1, 1, 3, -3, 8388607, -8388608, 100};
        dir_c = '{0, 0, 0, 8388607, -8388608, 8388607, -8388608, -8388608, 8388607, 8388607,
                  8388607, -8388608, -8388608, -1, -1, 4, 0, 1, -1, 1};
        phase_pp = '{0, 31, 16, 1, 17, 3, 5, 2};
        phase_pp[PHASES-1] = $urandom_range(0, 31);

        quiet_cycles = 0;
        gaps_on = 1'b1;
        rst_n <= 1'b0;
        sample_ch.valid         <= 1'b0;
        sample_ch.sine_sample   <= '0;
        sample_ch.cosine_sample <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.pole_pairs <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED; i++)
            send_pair(SAMPLE_BITS'(dir_s[i]), SAMPLE_BITS'(dir_c[i]));

        for (int p = 0; p < PHASES; p++)
        begin
            sample_ch.valid <= 1'b0;
            wait_drained();
            write_pole_pairs(PP_BITS'(phase_pp[p]));
            gaps_on = (p % 4 != 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_pair(s, c);
                send_pair(s, c);
            end
        end
        sample_ch.valid <= 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/eafsc_pkg.sv
rtl/eafsc_if.sv
rtl/eafsc_cordic.sv
rtl/electrical_angle_from_sin_cos_top.sv
rtl/eafsc_checker.sv
sim/tb.sv
